// ===== rtl/bdc_pkg.sv =====
package bdc_pkg;

  // coordinate and split parameter formats
  localparam int COORD_WIDTH = 24;
  localparam int T_FRAC_BITS = 16;

  // curve kind codes
  localparam logic [1:0] KIND_INVALID = 2'd0;
  localparam logic [1:0] KIND_POINT   = 2'd1;
  localparam logic [1:0] KIND_LINE    = 2'd2;
  localparam logic [1:0] KIND_CUBIC   = 2'd3;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic [T_FRAC_BITS:0] tfrac_t;

  // t equal to 1.0
  localparam tfrac_t T_ONE = {1'b1, {T_FRAC_BITS{1'b0}}};

  typedef struct packed {
    coord_t x;
    coord_t y;
  } pt_t;

  typedef struct packed {
    logic [1:0] curve_kind;
    coord_t     ax;
    coord_t     ay;
    coord_t     bx;
    coord_t     by;
    coord_t     cx;
    coord_t     cy;
    coord_t     dx;
    coord_t     dy;
    tfrac_t     split_at;
  } req_t;

  typedef struct packed {
    logic [1:0] half_kind;
    coord_t     out_ax;
    coord_t     out_ay;
    coord_t     out_bx;
    coord_t     out_by;
    coord_t     out_cx;
    coord_t     out_cy;
    coord_t     out_dx;
    coord_t     out_dy;
    logic       was_split;
    logic       last_half;
  } res_t;

endpackage

// ===== rtl/bdc_lerp.sv =====
module bdc_lerp import bdc_pkg::*; (
  input  logic   clk,
  input  pt_t    a,
  input  pt_t    b,
  input  tfrac_t t,
  output pt_t    r
);

  localparam int PW = COORD_WIDTH + T_FRAC_BITS + 3;
  // rounding constant, one half in units of t
  localparam logic signed [PW-1:0] RND =
    {{(PW-T_FRAC_BITS){1'b0}}, 1'b1, {(T_FRAC_BITS-1){1'b0}}};

  logic signed [COORD_WIDTH:0] dx;
  logic signed [COORD_WIDTH:0] dy;
  logic signed [PW-1:0] dx_ext;
  logic signed [PW-1:0] dy_ext;
  logic signed [PW-1:0] t_ext;
  logic signed [PW-1:0] px;
  logic signed [PW-1:0] py;
  logic signed [PW-1:0] px_q;
  logic signed [PW-1:0] py_q;
  logic signed [PW-1:0] rx;
  logic signed [PW-1:0] ry;
  pt_t a_q;

  // difference times t
  always_comb begin
    dx     = {b.x[COORD_WIDTH-1], b.x} - {a.x[COORD_WIDTH-1], a.x};
    dy     = {b.y[COORD_WIDTH-1], b.y} - {a.y[COORD_WIDTH-1], a.y};
    dx_ext = {{(PW-COORD_WIDTH-1){dx[COORD_WIDTH]}}, dx};
    dy_ext = {{(PW-COORD_WIDTH-1){dy[COORD_WIDTH]}}, dy};
    t_ext  = {{(PW-T_FRAC_BITS-1){1'b0}}, t};
    px     = dx_ext * t_ext;
    py     = dy_ext * t_ext;
  end

  always_ff @(posedge clk) begin
    px_q <= px;
    py_q <= py;
    a_q  <= a;
  end

  // round half up, scale back and add to the start point
  always_comb begin
    rx = (px_q + RND) >>> T_FRAC_BITS;
    ry = (py_q + RND) >>> T_FRAC_BITS;
  end

  always_ff @(posedge clk) begin
    r.x <= a_q.x + rx[COORD_WIDTH-1:0];
    r.y <= a_q.y + ry[COORD_WIDTH-1:0];
  end

endmodule

// ===== rtl/bdc_emit.sv =====
module bdc_emit import bdc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       valid,
  input  logic [1:0] kind,
  input  pt_t        a,
  input  pt_t        b,
  input  pt_t        d,
  input  pt_t        ab,
  input  pt_t        abc,
  input  pt_t        abcd,
  input  pt_t        bcd,
  input  pt_t        cd,
  output logic       result_valid,
  output res_t       result
);

  res_t first;
  res_t second;
  res_t second_q;
  logic pend;
  logic split;

  // build the halves of the current curve; points and invalid curves give only the first
  always_comb begin
    first  = '0;
    second = '0;
    split  = 1'b0;
    unique case (kind)
      KIND_CUBIC: begin
        split  = 1'b1;
        first  = '{KIND_CUBIC, a.x, a.y, ab.x, ab.y, abc.x, abc.y, abcd.x, abcd.y,
                   1'b1, 1'b0};
        second = '{KIND_CUBIC, abcd.x, abcd.y, bcd.x, bcd.y, cd.x, cd.y, d.x, d.y,
                   1'b1, 1'b1};
      end
      KIND_LINE: begin
        split  = 1'b1;
        first  = '{KIND_LINE, a.x, a.y, ab.x, ab.y, '0, '0, '0, '0, 1'b1, 1'b0};
        second = '{KIND_LINE, ab.x, ab.y, b.x, b.y, '0, '0, '0, '0, 1'b1, 1'b1};
      end
      KIND_POINT: begin
        first  = '{KIND_POINT, a.x, a.y, '0, '0, '0, '0, '0, '0, 1'b0, 1'b1};
      end
      default: begin
        first  = '{KIND_INVALID, '0, '0, '0, '0, '0, '0, '0, '0, 1'b0, 1'b1};
      end
    endcase
  end

  // strobe and pending second half
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      pend         <= 1'b0;
    end else begin
      result_valid <= valid | pend;
      pend         <= valid & split;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (valid) begin
      result   <= first;
      second_q <= second;
    end else if (pend) begin
      result   <= second_q;
    end
  end

endmodule

// ===== rtl/bezier_de_casteljau_split.sv =====
// The first result strobes on result_valid after the capture, lerp and emit registers;
// the second half of a split follows in the next cycle.
// Throughput: three interpolation levels of registered multipliers, one request per
// cycle inside; a line or cubic request raises busy for a single cycle, holding off
// the next request; points or invalid curves enter every cycle. Results cannot stall.
// Reset (rst, synchronous): clears busy, all valid bits and pend; no other state.
module bezier_de_casteljau_split import bdc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  req_t req,
  output logic result_valid,
  output res_t result
);

  localparam int DEPTH = 7;

  logic       accept;
  tfrac_t     t_sat;
  logic       v_pipe    [DEPTH];
  logic [1:0] kind_pipe [DEPTH];
  pt_t        a_pipe    [DEPTH];
  pt_t        b_pipe    [DEPTH];
  pt_t        d_pipe    [DEPTH];
  tfrac_t     t_pipe    [DEPTH-2];
  pt_t        c_q;
  pt_t        ab;
  pt_t        bc;
  pt_t        cd;
  pt_t        abc;
  pt_t        bcd;
  pt_t        abcd;
  pt_t        ab_dly    [4];
  pt_t        cd_dly    [4];
  pt_t        abc_dly   [2];
  pt_t        bcd_dly   [2];

  assign accept = start & ~busy;
  assign t_sat  = (req.split_at > T_ONE) ? T_ONE : req.split_at;

  // a split raises busy, holding off the next request
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else begin
      busy <= accept & ((req.curve_kind == KIND_LINE) | (req.curve_kind == KIND_CUBIC));
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) v_pipe[i] <= 1'b0;
    end else begin
      v_pipe[0] <= accept;
      for (int i = 1; i < DEPTH; i++) v_pipe[i] <= v_pipe[i-1];
    end
  end

  // input capture and side data delay lines
  always_ff @(posedge clk) begin
    kind_pipe[0] <= req.curve_kind;
    a_pipe[0]    <= '{req.ax, req.ay};
    b_pipe[0]    <= '{req.bx, req.by};
    c_q          <= '{req.cx, req.cy};
    d_pipe[0]    <= '{req.dx, req.dy};
    t_pipe[0]    <= t_sat;
    for (int i = 1; i < DEPTH; i++) begin
      kind_pipe[i] <= kind_pipe[i-1];
      a_pipe[i]    <= a_pipe[i-1];
      b_pipe[i]    <= b_pipe[i-1];
      d_pipe[i]    <= d_pipe[i-1];
    end
    for (int i = 1; i < DEPTH-2; i++) t_pipe[i] <= t_pipe[i-1];
    ab_dly[0]  <= ab;
    cd_dly[0]  <= cd;
    for (int i = 1; i < 4; i++) begin
      ab_dly[i] <= ab_dly[i-1];
      cd_dly[i] <= cd_dly[i-1];
    end
    abc_dly[0] <= abc;
    bcd_dly[0] <= bcd;
    abc_dly[1] <= abc_dly[0];
    bcd_dly[1] <= bcd_dly[0];
  end

  // first interpolation level
  bdc_lerp u_lerp_ab (.clk(clk), .a(a_pipe[0]), .b(b_pipe[0]), .t(t_pipe[0]), .r(ab));
  bdc_lerp u_lerp_bc (.clk(clk), .a(b_pipe[0]), .b(c_q),       .t(t_pipe[0]), .r(bc));
  bdc_lerp u_lerp_cd (.clk(clk), .a(c_q),       .b(d_pipe[0]), .t(t_pipe[0]), .r(cd));

  // second interpolation level
  bdc_lerp u_lerp_abc (.clk(clk), .a(ab), .b(bc), .t(t_pipe[2]), .r(abc));
  bdc_lerp u_lerp_bcd (.clk(clk), .a(bc), .b(cd), .t(t_pipe[2]), .r(bcd));

  // third interpolation level
  bdc_lerp u_lerp_abcd (.clk(clk), .a(abc), .b(bcd), .t(t_pipe[4]), .r(abcd));

  // result sequencing
  bdc_emit u_emit (
    .clk          (clk),
    .rst          (rst),
    .valid        (v_pipe[DEPTH-1]),
    .kind         (kind_pipe[DEPTH-1]),
    .a            (a_pipe[DEPTH-1]),
    .b            (b_pipe[DEPTH-1]),
    .d            (d_pipe[DEPTH-1]),
    .ab           (ab_dly[3]),
    .abc          (abc_dly[1]),
    .abcd         (abcd),
    .bcd          (bcd_dly[1]),
    .cd           (cd_dly[3]),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule

// ===== rtl/bdc_checker.sv =====
module bdc_props import bdc_pkg::*; (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic result_valid,
  input res_t result
);

  // busy only follows a taken request
  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    busy |-> $past(start & ~busy))
    else $error("busy without a preceding request");

  // busy lasts a single cycle
  a_busy_short: assert property (@(posedge clk) disable iff (rst)
    busy |=> !busy)
    else $error("busy held for more than one cycle");

  // a first half is always followed by its second half
  a_second_half: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.last_half) |=> (result_valid && result.last_half))
    else $error("second half missing");

  // unsplit results are single and final
  a_unsplit_last: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.was_split) |-> result.last_half)
    else $error("unsplit result not marked last");

endmodule

bind bezier_de_casteljau_split bdc_props u_bdc_props (.*);
